### rtl/core/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

### rtl/core/bgd_pkg.sv
// ----------------------------------------------------------------------------
// Button group debouncer package
// Field widths, item kinds, register indexes and defaults.
// ----------------------------------------------------------------------------
package bgd_pkg;

	localparam int KIND_W       = 2;
	localparam int IDX_W        = 3;
	localparam int SAMPLE_W     = 16;
	localparam int OUT_W        = 8;
	localparam int PERIOD_W     = 16;
	localparam int THRESH_W     = 16;
	localparam int MASK_W       = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam int DEF_NUM_BUTTONS = 8;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE      = 2'd0,
		KIND_TICK        = 2'd1,
		KIND_CLR_PRESS   = 2'd2,
		KIND_CLR_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD    = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_MASK      = 2'd2
	} cfg_idx_t;

endpackage

### rtl/core/button_group_debouncer.sv
// ----------------------------------------------------------------------------
// Button group debouncer
// Integrator debounce of a group of buttons with sticky press and release
// flags.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while its result is not stalled and
// returns one result for each item: the item is first captured in an input
// register, then one pass of logic updates the raw bits, or all integrators in
// parallel with the levels and flags, or the flags, which then stand as the
// result until it is taken. A stalled result holds the input register, and the
// input channel keeps accepting as soon as the result is taken in the same cycle.
// Configuration writes are taken at any time and should be made while idle.
`include "assert_macros.svh"

module button_group_debouncer #(
	parameter int NUM_BUTTONS = bgd_pkg::DEF_NUM_BUTTONS,
	parameter int COUNT_WIDTH = bgd_pkg::DEF_COUNT_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bgd_pkg::KIND_W-1:0]     kind,
	input  logic [bgd_pkg::IDX_W-1:0]      button_index,
	input  logic [bgd_pkg::SAMPLE_W-1:0]   sample_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bgd_pkg::OUT_W-1:0]      debounced_state,
	output logic [bgd_pkg::OUT_W-1:0]      press_flags,
	output logic [bgd_pkg::OUT_W-1:0]      release_flags,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int EXT_W = (COUNT_WIDTH > bgd_pkg::PERIOD_W) ? COUNT_WIDTH : bgd_pkg::PERIOD_W;

	logic [bgd_pkg::PERIOD_W-1:0] period_q;
	logic [bgd_pkg::THRESH_W-1:0] thresh_q;
	logic [bgd_pkg::MASK_W-1:0]   amask_q;

	logic                          valid_s1;
	logic [bgd_pkg::KIND_W-1:0]    kind_s1;
	logic [bgd_pkg::IDX_W-1:0]     idx_s1;
	logic [bgd_pkg::SAMPLE_W-1:0]  sample_s1;

	logic                          out_valid_q;
	logic [NUM_BUTTONS-1:0]        raw_q;
	logic [NUM_BUTTONS-1:0]        deb_q;
	logic [NUM_BUTTONS-1:0]        press_q;
	logic [NUM_BUTTONS-1:0]        rel_q;
	logic [COUNT_WIDTH-1:0]        integ_q [NUM_BUTTONS];

	logic                          advance;
	logic [EXT_W-1:0]              period_ext;
	logic [COUNT_WIDTH-1:0]        period_eff;
	logic [NUM_BUTTONS-1:0]        sel;
	logic [NUM_BUTTONS-1:0]        amask_ext;
	logic                          sample_on;
	logic [COUNT_WIDTH-1:0]        integ_nx [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]        deb_tick;
	logic [NUM_BUTTONS-1:0]        raw_d;
	logic [NUM_BUTTONS-1:0]        deb_d;
	logic [NUM_BUTTONS-1:0]        press_d;
	logic [NUM_BUTTONS-1:0]        rel_d;
	logic                          tick_d;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	assign debounced_state = bgd_pkg::OUT_W'(deb_q);
	assign press_flags     = bgd_pkg::OUT_W'(press_q);
	assign release_flags   = bgd_pkg::OUT_W'(rel_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= bgd_pkg::PERIOD_RESET;
			thresh_q <= '0;
			amask_q  <= '0;
		end else if (cfg_valid) begin
			case (bgd_pkg::cfg_idx_t'(cfg_index))
				bgd_pkg::CFG_PERIOD:    period_q <= cfg_data[bgd_pkg::PERIOD_W-1:0];
				bgd_pkg::CFG_THRESHOLD: thresh_q <= cfg_data[bgd_pkg::THRESH_W-1:0];
				bgd_pkg::CFG_MASK:      amask_q  <= cfg_data[bgd_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1   <= kind;
			idx_s1    <= button_index;
			sample_s1 <= sample_value;
		end
	end

	always_comb begin
		period_ext = EXT_W'(period_q);
		if (period_ext == '0) begin
			period_ext = EXT_W'(1);
		end
		if (period_ext > EXT_W'({COUNT_WIDTH{1'b1}})) begin
			period_ext = EXT_W'({COUNT_WIDTH{1'b1}});
		end
		period_eff = COUNT_WIDTH'(period_ext);
	end

	assign amask_ext = NUM_BUTTONS'(amask_q);

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			sel[i] = (int'(idx_s1) == i);
		end
	end

	always_comb begin
		if ((amask_ext & sel) != '0) begin
			sample_on = sample_s1 > thresh_q;
		end else begin
			sample_on = sample_s1 != '0;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (raw_q[i]) begin
				if (integ_q[i] < period_eff) begin
					integ_nx[i] = integ_q[i] + COUNT_WIDTH'(1);
				end else begin
					integ_nx[i] = period_eff;
				end
			end else if (integ_q[i] != '0) begin
				integ_nx[i] = integ_q[i] - COUNT_WIDTH'(1);
			end else begin
				integ_nx[i] = integ_q[i];
			end
			if (integ_nx[i] == '0) begin
				deb_tick[i] = 1'b0;
			end else if (integ_nx[i] >= period_eff) begin
				deb_tick[i] = 1'b1;
			end else begin
				deb_tick[i] = deb_q[i];
			end
		end
	end

	always_comb begin
		raw_d   = raw_q;
		deb_d   = deb_q;
		press_d = press_q;
		rel_d   = rel_q;
		tick_d  = 1'b0;
		case (bgd_pkg::kind_t'(kind_s1))
			bgd_pkg::KIND_SAMPLE: begin
				raw_d = sample_on ? (raw_q | sel) : (raw_q & ~sel);
			end
			bgd_pkg::KIND_TICK: begin
				tick_d  = 1'b1;
				deb_d   = deb_tick;
				press_d = press_q | (deb_tick & ~deb_q);
				rel_d   = rel_q | (~deb_tick & deb_q);
			end
			bgd_pkg::KIND_CLR_PRESS: begin
				press_d = press_q & ~sel;
			end
			bgd_pkg::KIND_CLR_RELEASE: begin
				rel_d = rel_q & ~sel;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			raw_q       <= '0;
			deb_q       <= '0;
			press_q     <= '0;
			rel_q       <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				integ_q[i] <= '0;
			end
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				raw_q   <= raw_d;
				deb_q   <= deb_d;
				press_q <= press_d;
				rel_q   <= rel_d;
				if (tick_d) begin
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						integ_q[i] <= integ_nx[i];
					end
				end
			end
		end
	end

	// A waiting result must not change under the consumer.
	`ASSERT_CLK(a_result_holds, clk, arst_n, out_valid_q && !out_ready |=> $stable(deb_q) && $stable(press_q) && $stable(rel_q), "result changed while stalled")
	// Debounced levels move only on a tick.
	`ASSERT_CLK(a_deb_on_tick, clk, arst_n, !(advance && tick_d) |=> $stable(deb_q), "debounced level changed without a tick")
	// Press flags are only ever set by a tick.
	`ASSERT_CLK(a_press_on_tick, clk, arst_n, !(advance && tick_d) |=> (press_q & ~$past(press_q)) == '0, "press flag set without a tick")
	// A stalled input register keeps its item.
	`ASSERT_CLK(a_s1_holds, clk, arst_n, valid_s1 && !advance |=> valid_s1 && $stable(kind_s1) && $stable(idx_s1) && $stable(sample_s1), "input register lost a stalled item")
	// The input register cannot advance into a result that is still waiting.
	`ASSERT_NEVER(a_no_overrun, clk, arst_n, advance && out_valid_q && !out_ready, "result overwritten before transfer")

endmodule
